// ----- sv/rsi_pkg.sv -----
// Package with command and status types shared by the intersector modules.
`default_nettype none

package rsi_pkg;

  // Register indexes of the configuration port.
  localparam logic REG_SEGMENTS_IN_USE = 1'b0;
  localparam logic REG_DET_EPSILON     = 1'b1;

  localparam int CFG_DATA_BITS  = 20;
  localparam int SEG_INDEX_BITS = 6;
  localparam int SEG_COUNT_BITS = 7;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CAST = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seg;
    logic ray_load;
    logic cnt_clr;
    logic cnt_inc;
    logic fetch;
    logic calc_diff;
    logic calc_mul;
    logic calc_det;
    logic calc_prod;
    logic div_start;
    logic calc_hit;
    logic calc_dot;
    logic pend_set;
    logic pend_clr;
    logic out_pend;
    logic out_nohit;
    logic out_last;
  } rsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seg_more;
    logic det_skip;
    logic tau_skip;
    logic div_done;
    logic fwd_ok;
    logic pend_valid;
    logic out_free;
  } rsi_status_t;

endpackage

`default_nettype wire

// ----- sv/rsi_div.sv -----
// Restoring divider that returns the quotient rounded to nearest, ties away from zero.
`default_nettype none

module rsi_div
  import rsi_pkg::*;
#(
  parameter int W = 35,
  parameter int D = 17
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W+D-1:0] dividend,
  input  wire logic [W-1:0]   divisor,
  output logic                done,
  output logic [D-1:0]        quot
);

  localparam int CB = $clog2(D + 1);

  logic [W+D-1:0] rem_r, rem_nxt;
  logic [W+D-1:0] dsh_r, dsh_nxt;
  logic [D-1:0]   q_r, q_nxt;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic           ge;
  logic [W:0]     rem2;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    ge       = (rem_r >= dsh_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend;
      dsh_nxt = (W+D)'({1'b0, divisor}) << (D - 1);
      q_nxt   = '0;
      cnt_nxt = CB'(D);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[D-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CB'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // The remainder is below the divisor here, so it fits W bits.
  assign rem2 = {rem_r[W-1:0], 1'b0};
  assign quot = q_r + D'(rem2 >= (W+1)'(divisor));
  assign done = done_r;

endmodule

`default_nettype wire

// ----- sv/rsi_ctrl.sv -----
// Controller state machine that sequences a cast over the segment table.
`default_nettype none

module rsi_ctrl
  import rsi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_func,
  output logic             in_stall,
  input  wire rsi_status_t status,
  output rsi_cmd_t         cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SEL   = 14'b00000000000010,
    S_FETCH = 14'b00000000000100,
    S_DIFF  = 14'b00000000001000,
    S_MUL   = 14'b00000000010000,
    S_DET   = 14'b00000000100000,
    S_CHK   = 14'b00000001000000,
    S_DIVS  = 14'b00000010000000,
    S_DIVW  = 14'b00000100000000,
    S_HIT   = 14'b00001000000000,
    S_DOT   = 14'b00010000000000,
    S_FWD   = 14'b00100000000000,
    S_PEND  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_CAST) begin
            cmd.ray_load = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_nxt    = S_SEL;
          end else begin
            cmd.load_seg = 1'b1;
          end
        end
      end
      S_SEL: begin
        state_nxt = status.seg_more ? S_FETCH : S_FIN;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = S_DET;
      end
      S_DET: begin
        cmd.calc_det = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        if (status.det_skip || status.tau_skip) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SEL;
        end else begin
          cmd.calc_prod = 1'b1;
          state_nxt     = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          state_nxt = S_HIT;
        end
      end
      S_HIT: begin
        cmd.calc_hit = 1'b1;
        state_nxt    = S_DOT;
      end
      S_DOT: begin
        cmd.calc_dot = 1'b1;
        state_nxt    = S_FWD;
      end
      S_FWD: begin
        if (status.fwd_ok) begin
          state_nxt = S_PEND;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SEL;
        end
      end
      // A held hit goes out once a newer one shows it is not the last.
      S_PEND: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.out_pend = status.pend_valid;
          cmd.pend_set = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = S_SEL;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_last  = 1'b1;
          cmd.out_pend  = status.pend_valid;
          cmd.out_nohit = !status.pend_valid;
          cmd.pend_clr  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rsi_dp.sv -----
// Datapath: segment table, configuration, geometry arithmetic and result registers.
`default_nettype none

module rsi_dp
  import rsi_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rsi_cmd_t                     cmd,
  output rsi_status_t                       status,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic [SEG_INDEX_BITS-1:0]    in_seg_index,
  input  wire logic signed [COORD_BITS-1:0] in_point_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_point_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_b_y,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic signed [COORD_BITS-1:0]      out_hit_x,
  output logic signed [COORD_BITS-1:0]      out_hit_y,
  output logic [SEG_INDEX_BITS-1:0]         out_hit_segment,
  output logic                              out_last
);

  localparam int C    = COORD_BITS;
  localparam int D    = C + 1;
  localparam int P    = 2 * D;
  localparam int W    = P + 1;
  localparam int M    = W + D;
  localparam int CW   = (W > CFG_DATA_BITS) ? W : CFG_DATA_BITS;
  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int WIDE = 9;

  // Configuration registers.
  logic [SEG_COUNT_BITS-1:0] seg_in_use_r;
  logic [CFG_DATA_BITS-1:0]  eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_in_use_r <= '0;
      eps_r        <= CFG_DATA_BITS'(10);
    end else if (cfg_we) begin
      if (cfg_index == REG_SEGMENTS_IN_USE) begin
        seg_in_use_r <= cfg_wdata[SEG_COUNT_BITS-1:0];
      end else begin
        eps_r <= cfg_wdata;
      end
    end
  end

  // Segment table: ax, ay, bx, by packed per entry.
  logic [4*C-1:0] mem [MAX_SEGMENTS];
  logic [4*C-1:0] ent_r;
  logic [CNTW-1:0] cnt_r;
  logic [WIDE-1:0] idx_wide;
  logic [WIDE-1:0] cnt_wide;
  logic            idx_ok;

  assign idx_wide = WIDE'(in_seg_index);
  assign cnt_wide = WIDE'(cnt_r);
  assign idx_ok   = (int'(in_seg_index) < MAX_SEGMENTS);

  always_ff @(posedge clk) begin
    if (cmd.load_seg && idx_ok) begin
      mem[idx_wide[AW-1:0]] <= {in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y};
    end
    if (cmd.fetch) begin
      ent_r <= mem[cnt_wide[AW-1:0]];
    end
  end

  // Segment counter against the clamped count in use.
  logic [WIDE-1:0] n_eff;

  assign n_eff = (int'(seg_in_use_r) > MAX_SEGMENTS) ? WIDE'(MAX_SEGMENTS)
                                                     : WIDE'(seg_in_use_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Ray origin and direction.
  logic signed [C-1:0] rax_r, ray_r;
  logic signed [D-1:0] rdx_r, rdy_r;

  always_ff @(posedge clk) begin
    if (cmd.ray_load) begin
      rax_r <= in_point_a_x;
      ray_r <= in_point_a_y;
      rdx_r <= D'(in_point_b_x) - D'(in_point_a_x);
      rdy_r <= D'(in_point_b_y) - D'(in_point_a_y);
    end
  end

  // Segment differences.
  logic signed [C-1:0] sax_r, say_r;
  logic signed [D-1:0] d1x_r, d1y_r, qx_r, qy_r;
  logic signed [C-1:0] e_ax, e_ay, e_bx, e_by;

  assign e_ax = ent_r[4*C-1:3*C];
  assign e_ay = ent_r[3*C-1:2*C];
  assign e_bx = ent_r[2*C-1:C];
  assign e_by = ent_r[C-1:0];

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      sax_r <= e_ax;
      say_r <= e_ay;
      d1x_r <= D'(e_bx) - D'(e_ax);
      d1y_r <= D'(e_by) - D'(e_ay);
      qx_r  <= D'(rax_r) - D'(e_ax);
      qy_r  <= D'(ray_r) - D'(e_ay);
    end
  end

  // Cross products for the determinant and the tau numerator.
  logic signed [P-1:0] p0_r, p1_r, p2_r, p3_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_mul) begin
      p0_r <= P'(d1x_r) * P'(rdy_r);
      p1_r <= P'(rdx_r) * P'(d1y_r);
      p2_r <= P'(rdy_r) * P'(qx_r);
      p3_r <= P'(rdx_r) * P'(qy_r);
    end
  end

  // Determinant and numerator, signs normalized so the determinant is not negative.
  logic signed [W-1:0] det_c, num_c, det_r, num_r;

  assign det_c = W'(p0_r) - W'(p1_r);
  assign num_c = W'(p2_r) - W'(p3_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_det) begin
      det_r <= det_c[W-1] ? -det_c : det_c;
      num_r <= det_c[W-1] ? -num_c : num_c;
    end
  end

  // Products of tau numerator and segment direction.
  logic signed [M-1:0] mx_r, my_r;
  logic [M-1:0]        mag_x, mag_y;

  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      mx_r <= M'(num_r) * M'(d1x_r);
      my_r <= M'(num_r) * M'(d1y_r);
    end
  end

  assign mag_x = mx_r[M-1] ? M'(-mx_r) : M'(mx_r);
  assign mag_y = my_r[M-1] ? M'(-my_r) : M'(my_r);

  // Two division lanes, one per axis.
  logic         done_x, done_y;
  logic [D-1:0] quot_x, quot_y;

  rsi_div #(.W(W), .D(D)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_x),
    .divisor  (det_r[W-1:0]),
    .done     (done_x),
    .quot     (quot_x)
  );

  rsi_div #(.W(W), .D(D)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_y),
    .divisor  (det_r[W-1:0]),
    .done     (done_y),
    .quot     (quot_y)
  );

  // Hit point: segment start plus signed rounded offset, saturated.
  logic signed [C+1:0] qxs, qys, hxw, hyw;
  logic signed [C-1:0] hx_r, hy_r;
  localparam logic signed [C+1:0] HI = (C+2)'((64'sd1 <<< (C - 1)) - 1);
  localparam logic signed [C+1:0] LO = -HI - (C+2)'(1);

  assign qxs = $signed({1'b0, quot_x});
  assign qys = $signed({1'b0, quot_y});
  assign hxw = (C+2)'(sax_r) + (mx_r[M-1] ? -qxs : qxs);
  assign hyw = (C+2)'(say_r) + (my_r[M-1] ? -qys : qys);

  always_ff @(posedge clk) begin
    if (cmd.calc_hit) begin
      hx_r <= (hxw > HI) ? C'(HI) : ((hxw < LO) ? C'(LO) : C'(hxw));
      hy_r <= (hyw > HI) ? C'(HI) : ((hyw < LO) ? C'(LO) : C'(hyw));
    end
  end

  // Forward test on the ray: (hit - origin) . direction.
  logic signed [D-1:0] ex, ey;
  logic signed [P-1:0] e1_r, e2_r;
  logic signed [P:0]   dot;

  assign ex  = D'(hx_r) - D'(rax_r);
  assign ey  = D'(hy_r) - D'(ray_r);
  assign dot = (P+1)'(e1_r) + (P+1)'(e2_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_dot) begin
      e1_r <= P'(ex) * P'(rdx_r);
      e2_r <= P'(ey) * P'(rdy_r);
    end
  end

  // Hit held back until it is known whether it is the last one.
  logic                      pend_v_r;
  logic signed [C-1:0]       pend_x_r, pend_y_r;
  logic [SEG_INDEX_BITS-1:0] pend_seg_r;

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_x_r   <= hx_r;
      pend_y_r   <= hy_r;
      pend_seg_r <= cnt_wide[SEG_INDEX_BITS-1:0];
    end
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.pend_set) begin
      pend_v_r <= 1'b1;
    end else if (cmd.pend_clr) begin
      pend_v_r <= 1'b0;
    end
  end

  // Output register.
  logic                      out_valid_r;
  logic                      out_hit_r, out_last_r;
  logic signed [C-1:0]       out_x_r, out_y_r;
  logic [SEG_INDEX_BITS-1:0] out_seg_r;
  logic                      out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.out_pend) begin
      out_hit_r  <= 1'b1;
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_seg_r  <= pend_seg_r;
      out_last_r <= cmd.out_last;
    end else if (cmd.out_nohit) begin
      out_hit_r  <= 1'b0;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_seg_r  <= '0;
      out_last_r <= 1'b1;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_pend || cmd.out_nohit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_x       = out_x_r;
  assign out_hit_y       = out_y_r;
  assign out_hit_segment = out_seg_r;
  assign out_last        = out_last_r;

  // Status to the controller.
  always_comb begin
    status            = '0;
    status.seg_more   = (cnt_wide < n_eff);
    status.det_skip   = (det_r == '0) || (CW'(det_r) < CW'(eps_r));
    status.tau_skip   = num_r[W-1] || (num_r > det_r);
    status.div_done   = done_x && done_y;
    status.fwd_ok     = !dot[P];
    status.pend_valid = pend_v_r;
    status.out_free   = out_free;
  end

endmodule

`default_nettype wire

// ----- sv/ray_segment_intersector.sv -----
// Top level of the ray against segment table intersector.
//
//   channel  direction  handshake         payload
//   in_      input      in_valid/stall    func, seg_index, point_a_x/y, point_b_x/y
//   out_     output     out_valid/stall   hit, hit_x, hit_y, hit_segment, last
//   cfg_     input      cfg_we            cfg_index, cfg_wdata
//
// A load item writes one table entry. A cast walks the segments in use: each
// is fetched, differenced, multiplied and tested; one skipped as parallel or off
// range goes on to the next, one in range runs the two 17-step dividers that form
// the hit point and is then dropped if it lies behind the ray. Up to 64 segments
// are walked. Reset is synchronous and active low; the table holds no valid bits.
// A stalled output holds the walk only when a second result is ready to go out.
`default_nettype none

module ray_segment_intersector
  import rsi_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]     cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic [SEG_INDEX_BITS-1:0]    in_seg_index,
  input  wire logic signed [COORD_BITS-1:0] in_point_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_point_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_b_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_hit,
  output logic signed [COORD_BITS-1:0]      out_hit_x,
  output logic signed [COORD_BITS-1:0]      out_hit_y,
  output logic [SEG_INDEX_BITS-1:0]         out_hit_segment,
  output logic                              out_last
);

  rsi_cmd_t    cmd;
  rsi_status_t status;

  rsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rsi_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_seg_index    (in_seg_index),
    .in_point_a_x    (in_point_a_x),
    .in_point_a_y    (in_point_a_y),
    .in_point_b_x    (in_point_b_x),
    .in_point_b_y    (in_point_b_y),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_hit_x       (out_hit_x),
    .out_hit_y       (out_hit_y),
    .out_hit_segment (out_hit_segment),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/sv/ray_segment_checker.sv -----
// Checker that predicts and compares the results of the ray segment intersector.
`timescale 1ns / 100ps
`default_nettype none

module ray_segment_checker
  import rsi_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic                      in_func,
  input  wire logic [SEG_INDEX_BITS-1:0] in_seg_index,
  input  wire logic signed [15:0]        in_point_a_x,
  input  wire logic signed [15:0]        in_point_a_y,
  input  wire logic signed [15:0]        in_point_b_x,
  input  wire logic signed [15:0]        in_point_b_y,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic                      out_hit,
  input  wire logic signed [15:0]        out_hit_x,
  input  wire logic signed [15:0]        out_hit_y,
  input  wire logic [SEG_INDEX_BITS-1:0] out_hit_segment,
  input  wire logic                      out_last,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic              hit;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]        seg;
    logic              last;
  } hit_rec_t;

  // Shadow of the segment table and the two registers.
  longint   seg_ax [64];
  longint   seg_ay [64];
  longint   seg_bx [64];
  longint   seg_by [64];
  int       seg_limit;
  longint   eps;
  hit_rec_t expected_hits[$];

  // Rounds p / d to nearest with ties away from zero; d is positive.
  function automatic longint round_quot(longint p, longint d);
    longint m, q, r;
    m = (p < 0) ? -p : p;
    q = m / d;
    r = m % d;
    if (r >= d - r) q++;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Walks the table for one cast and queues every hit in table order.
  task automatic predict_cast(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, d1x, d1y, det, num, hx, hy, dot, mag;
    hit_rec_t rec;
    int found;
    found = 0;
    dx = bx - ax;
    dy = by - ay;
    for (int i = 0; i < seg_limit; i++) begin
      d1x = seg_bx[i] - seg_ax[i];
      d1y = seg_by[i] - seg_ay[i];
      det = d1x * dy - dx * d1y;
      mag = (det < 0) ? -det : det;
      if (det == 0 || mag < eps) continue;
      num = dy * (ax - seg_ax[i]) - dx * (ay - seg_ay[i]);
      if (det < 0) begin
        det = -det;
        num = -num;
      end
      if (num < 0 || num > det) continue;
      hx = clamp_coord(seg_ax[i] + round_quot(num * d1x, det));
      hy = clamp_coord(seg_ay[i] + round_quot(num * d1y, det));
      dot = (hx - ax) * dx + (hy - ay) * dy;
      if (dot < 0) continue;
      rec = '{hit: 1'b1, x: hx[15:0], y: hy[15:0], seg: i[5:0], last: 1'b0};
      expected_hits = {expected_hits, rec};
      found++;
    end
    if (found == 0) begin
      rec = '{hit: 1'b0, x: '0, y: '0, seg: '0, last: 1'b1};
      expected_hits = {expected_hits, rec};
    end else begin
      expected_hits[expected_hits.size()-1].last = 1'b1;
    end
  endtask

  // Tracks configuration and input items, and compares each result item.
  always @(posedge clk) begin
    hit_rec_t exp_rec;
    if (!rst_n) begin
      eps        = 10;
      seg_limit  = 0;
      fail_count = 0;
      expected_hits.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SEGMENTS_IN_USE)
          seg_limit = (cfg_wdata[6:0] > 64) ? 64 : int'(cfg_wdata[6:0]);
        else
          eps = longint'(cfg_wdata);
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_LOAD) begin
          seg_ax[in_seg_index] = in_point_a_x;
          seg_ay[in_seg_index] = in_point_a_y;
          seg_bx[in_seg_index] = in_point_b_x;
          seg_by[in_seg_index] = in_point_b_y;
        end else begin
          predict_cast(in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("Result item with no expectation waiting");
          fail_count++;
        end else begin
          exp_rec = expected_hits.pop_front();
          if (out_hit !== exp_rec.hit) begin
            $error("hit: expected %0d, actual %0d", exp_rec.hit, out_hit);
            fail_count++;
          end
          if (out_hit_x !== exp_rec.x) begin
            $error("hit_x: expected %0d, actual %0d", exp_rec.x, out_hit_x);
            fail_count++;
          end
          if (out_hit_y !== exp_rec.y) begin
            $error("hit_y: expected %0d, actual %0d", exp_rec.y, out_hit_y);
            fail_count++;
          end
          if (out_hit_segment !== exp_rec.seg) begin
            $error("hit_segment: expected %0d, actual %0d", exp_rec.seg, out_hit_segment);
            fail_count++;
          end
          if (out_last !== exp_rec.last) begin
            $error("last: expected %0d, actual %0d", exp_rec.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_ray_segment_intersector.sv -----
// Top of the intersector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none

module tb_ray_segment_intersector
  import rsi_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = REG_SEGMENTS_IN_USE;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_func = FUNC_LOAD;
  logic [SEG_INDEX_BITS-1:0] in_seg_index = '0;
  logic signed [15:0]        in_point_a_x = '0;
  logic signed [15:0]        in_point_a_y = '0;
  logic signed [15:0]        in_point_b_x = '0;
  logic signed [15:0]        in_point_b_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit;
  logic signed [15:0]        out_hit_x;
  logic signed [15:0]        out_hit_y;
  logic [SEG_INDEX_BITS-1:0] out_hit_segment;
  logic                      out_last;
  int                        fail_count;
  int                        pending;
  logic                      no_idle = 1'b0;
  int                        stall_left = 0;
  int                        quiet_cycles = 0;

  always #5 clk = ~clk;

  ray_segment_intersector u_top (.*);

  ray_segment_checker u_checker (.*);

  // Receiver draws a stall length after every accepted result item.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      w = no_idle ? 0 : $urandom_range(0, 13);
      stall_left <= w;
      out_stall  <= (w != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one item after a random gap and waits for it to be taken.
  task automatic send_item(logic func, logic [5:0] idx, logic signed [15:0] ax,
                           logic signed [15:0] ay, logic signed [15:0] bx,
                           logic signed [15:0] by);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_seg_index <= idx;
    in_point_a_x <= ax;
    in_point_a_y <= ay;
    in_point_b_x <= bx;
    in_point_b_y <= by;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Writes one register once the block has gone idle.
  task automatic write_reg(logic idx, int value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 8192)) - 16'sd4096;
  endfunction

  // Random cast, seg_index carries noise since a cast ignores it.
  task automatic random_cast();
    send_item(FUNC_CAST, 6'($urandom()), rand_coord(), rand_coord(), rand_coord(),
              rand_coord());
  endtask

  initial begin
    int seg_cfg[4];
    int eps_cfg[4];
    seg_cfg = '{64, 1, 17, 64};
    eps_cfg = '{1048575, 0, 10, 3000};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no segments in use a cast must report no hit.
    send_item(FUNC_CAST, 6'd63, 16'sd0, 16'sd0, 16'sd100, 16'sd100);

    // Horizontal, vertical, full-range diagonal and degenerate segments.
    send_item(FUNC_LOAD, 6'd0, -16'sd1024, 16'sd0, 16'sd1024, 16'sd0);
    send_item(FUNC_LOAD, 6'd1, 16'sd2048, -16'sd1024, 16'sd2048, 16'sd1024);
    send_item(FUNC_LOAD, 6'd2, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_item(FUNC_LOAD, 6'd3, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
    write_reg(REG_SEGMENTS_IN_USE, 4);
    write_reg(REG_DET_EPSILON, 0);

    // Forward hit, backward ray, zero direction, parallel ray, extreme corners.
    send_item(FUNC_CAST, 6'd0, 16'sd0, -16'sd2048, 16'sd0, -16'sd1024);
    send_item(FUNC_CAST, 6'd0, 16'sd0, -16'sd2048, 16'sd0, -16'sd3000);
    send_item(FUNC_CAST, 6'd0, 16'sd77, 16'sd77, 16'sd77, 16'sd77);
    send_item(FUNC_CAST, 6'd0, 16'sd0, 16'sd100, 16'sd10, 16'sd100);
    send_item(FUNC_CAST, 6'd0, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_item(FUNC_CAST, 6'd0, 16'sd0, 16'sd300, 16'sd4000, 16'sd300);
    send_item(FUNC_CAST, 6'd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    write_reg(REG_DET_EPSILON, 1048575);
    send_item(FUNC_CAST, 6'd0, 16'sd0, -16'sd2048, 16'sd0, -16'sd1024);

    // Fill the whole table, then run phases of mixed casts and reloads.
    for (int i = 0; i < 64; i++)
      send_item(FUNC_LOAD, i[5:0], rand_coord(), rand_coord(), rand_coord(),
                rand_coord());
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_SEGMENTS_IN_USE, seg_cfg[ph]);
      write_reg(REG_DET_EPSILON, eps_cfg[ph]);
      no_idle = (ph == 3);
      for (int k = 0; k < 26; k++) begin
        if (ph == 2 && k == 13) drain_results();
        if ($urandom_range(0, 3) == 0)
          send_item(FUNC_LOAD, 6'($urandom()), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
        else
          random_cast();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
